/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is low
`define ALAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ALAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/alas_pkg.sv */
`timescale 1ns / 1ps

package alas_pkg;

    // board geometry
    localparam int unsigned COORD_W = 6;
    localparam int unsigned SIDE_W  = 7;
    localparam int unsigned ADDR_W  = 2 * COORD_W;
    localparam int unsigned CELL_W  = 3;
    localparam logic [SIDE_W-1:0] MAX_SIDE = 7'd64;

    // cell status codes
    localparam logic [CELL_W-1:0] DEAD_STATUS = 3'd4;
    localparam logic [CELL_W-1:0] BORN_STATUS = 3'd0;

    // item function codes
    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;

    // register map
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_BOARD_SIZE = 1'b0;
    localparam logic [SIDE_W-1:0] BOARD_SIZE_RESET = 7'd64;

endpackage

/* rtl/aging_life_automaton_step_core.sv */
`timescale 1ns / 1ps
// results: write, no-op and flagged items go straight to the output register, in-range reads
//   pass the registered store read first; advance sweeps the board row by row, then copies the
//   scratch store back; one shared neighbor-count and rule unit sees one cell per column load
// throughput: one item at a time, the next is taken once the result enters the output register
// reset: synchronous active low; a clearing pass sets every cell dead,
//   input stalls meanwhile, board_size resets to 64
module aging_life_automaton_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic [2:0]  i_write_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_read_value,
    output logic        o_range_error,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_COPY,
        ST_FIN
    } t_state;

    // neighbor count of the 3x3 window, center excluded
    function automatic logic [3:0] count_live(input logic [7:0] bits);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, bits[i]};
        end
        return n;
    endfunction

    // life rule followed by aging
    function automatic logic [2:0] next_status(input logic [2:0] cur, input logic [3:0] n);
        logic [2:0] v;
        if (cur != alas_pkg::DEAD_STATUS) begin
            v = ((n == 4'd2) || (n == 4'd3)) ? cur : alas_pkg::DEAD_STATUS;
        end else begin
            v = (n == 4'd3) ? alas_pkg::BORN_STATUS : alas_pkg::DEAD_STATUS;
        end
        if (((cur == alas_pkg::BORN_STATUS) && (v == alas_pkg::BORN_STATUS)) ||
            ((v != 3'd0) && (v < alas_pkg::DEAD_STATUS))) begin
            v = v + 3'd1;
        end
        return v;
    endfunction

    // storage
    logic [2:0] cell_store [4096];
    logic [2:0] next_store [4096];
    logic [2:0] r_rdata;
    logic [2:0] r_next_rdata;

    // control registers
    t_state      r_state, n_state;
    logic [6:0]  r_board_size;
    logic [11:0] r_clr, n_clr;
    logic [6:0]  r_row, n_row;
    logic [6:0]  r_lc, n_lc;
    logic [1:0]  r_k, n_k;
    logic        r_pend_ok, n_pend_ok;
    logic [1:0]  r_cap, n_cap;
    logic [2:0]  r_cap_stat, n_cap_stat;
    logic [2:0]  r_mid, n_mid;
    logic [2:0]  r_right, n_right;
    logic [2:0]  r_right_stat, n_right_stat;
    logic [6:0]  r_cr, n_cr;
    logic [6:0]  r_cc, n_cc;
    logic        r_cp_go, n_cp_go;
    logic        r_wb_valid, n_wb_valid;
    logic [11:0] r_wb_addr, n_wb_addr;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_read_value, n_read_value;
    logic        r_range_error, n_range_error;
    logic [2:0]  r_res_value, n_res_value;
    logic        r_res_err, n_res_err;

    // datapath signals
    logic [6:0]  side;
    logic        out_free;
    logic        in_range;
    logic [2:0]  wv_clamp;
    logic [6:0]  nb_sum;
    logic [6:0]  nb_row;
    logic        nb_ok;
    logic        live_in;
    logic [2:0]  new_col;
    logic [3:0]  nb_count;
    logic [2:0]  nxt;
    logic [6:0]  cell_col;
    logic        next_we;
    logic        cell_we;
    logic [11:0] cell_waddr;
    logic [2:0]  cell_wdata;
    logic [11:0] cell_raddr;
    logic [11:0] next_raddr;
    logic        res_go;
    logic [2:0]  res_value;
    logic        res_err;

    // effective side saturates at the store size
    assign side     = (r_board_size > alas_pkg::MAX_SIDE) ? alas_pkg::MAX_SIDE : r_board_size;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_range = ({1'b0, i_row} < side) && ({1'b0, i_col} < side);
    assign wv_clamp = (i_write_value > alas_pkg::DEAD_STATUS) ? alas_pkg::DEAD_STATUS
                                                              : i_write_value;

    // neighbor row of the current column load, dead outside the board
    assign nb_sum  = r_row + {5'b00000, r_k};
    assign nb_row  = nb_sum - 7'd1;
    assign nb_ok   = (r_k != 2'd3) && (nb_sum != 7'd0) && (nb_row < side) && (r_lc < side);
    assign live_in = r_pend_ok && (r_rdata != alas_pkg::DEAD_STATUS);
    assign new_col = {live_in, r_cap[1], r_cap[0]};

    // shared rule unit: left = r_mid, center column = r_right, right = new_col
    assign nb_count = count_live({new_col, r_right[2], r_right[0], r_mid});
    assign nxt      = next_status(r_right_stat, nb_count);
    assign cell_col = r_lc - 7'd1;
    assign next_we  = (r_state == ST_LOAD) && (r_k == 2'd3) && (r_lc != 7'd0);

    assign next_raddr = {r_cr[5:0], r_cc[5:0]};

    // cell store port selection
    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = r_wb_addr;
        cell_wdata = r_next_rdata;
        cell_raddr = {i_row, i_col};
        unique case (r_state)
            ST_CLEAR: begin
                cell_we    = 1'b1;
                cell_waddr = r_clr;
                cell_wdata = alas_pkg::DEAD_STATUS;
            end
            ST_IDLE: begin
                if (i_in_valid && (i_func == alas_pkg::FUNC_WRITE) && in_range) begin
                    cell_we    = 1'b1;
                    cell_waddr = {i_row, i_col};
                    cell_wdata = wv_clamp;
                end
            end
            ST_LOAD: begin
                cell_raddr = {nb_row[5:0], r_lc[5:0]};
            end
            ST_COPY: begin
                cell_we = r_wb_valid;
            end
            default: begin
            end
        endcase
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            cell_store[cell_waddr] <= cell_wdata;
        end
        r_rdata <= cell_store[cell_raddr];
    end

    // scratch store for the generation being built
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_store[{r_row[5:0], cell_col[5:0]}] <= nxt;
        end
        r_next_rdata <= next_store[next_raddr];
    end

    // sequencer next state
    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_row         = r_row;
        n_lc          = r_lc;
        n_k           = r_k;
        n_pend_ok     = r_pend_ok;
        n_cap         = r_cap;
        n_cap_stat    = r_cap_stat;
        n_mid         = r_mid;
        n_right       = r_right;
        n_right_stat  = r_right_stat;
        n_cr          = r_cr;
        n_cc          = r_cc;
        n_cp_go       = r_cp_go;
        n_wb_valid    = r_wb_valid;
        n_wb_addr     = r_wb_addr;
        n_out_valid   = r_out_valid && i_out_stall;
        n_read_value  = r_read_value;
        n_range_error = r_range_error;
        n_res_value   = r_res_value;
        n_res_err     = r_res_err;
        res_go        = 1'b0;
        res_value     = 3'd0;
        res_err       = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 12'd1;
                if (r_clr == 12'hfff) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func)
                        alas_pkg::FUNC_WRITE: begin
                            res_go  = 1'b1;
                            res_err = !in_range;
                        end
                        alas_pkg::FUNC_READ: begin
                            if (in_range) begin
                                n_state = ST_READ;
                            end else begin
                                res_go  = 1'b1;
                                res_err = 1'b1;
                            end
                        end
                        alas_pkg::FUNC_ADVANCE: begin
                            if (side == 7'd0) begin
                                res_go = 1'b1;
                            end else begin
                                n_row   = 7'd0;
                                n_lc    = 7'd0;
                                n_k     = 2'd0;
                                n_mid   = 3'd0;
                                n_right = 3'd0;
                                n_state = ST_LOAD;
                            end
                        end
                        default: begin
                            res_go = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_go    = 1'b1;
                res_value = r_rdata;
            end
            ST_LOAD: begin
                n_k = r_k + 2'd1;
                if (r_k != 2'd3) begin
                    n_pend_ok = nb_ok;
                end
                unique case (r_k)
                    2'd1: n_cap[0] = live_in;
                    2'd2: begin
                        n_cap[1]   = live_in;
                        n_cap_stat = r_rdata;
                    end
                    2'd3: begin
                        // slide the window one column right
                        n_mid        = r_right;
                        n_right      = new_col;
                        n_right_stat = r_cap_stat;
                        if (r_lc == side) begin
                            if (r_row == side - 7'd1) begin
                                n_cr       = 7'd0;
                                n_cc       = 7'd0;
                                n_cp_go    = 1'b1;
                                n_wb_valid = 1'b0;
                                n_state    = ST_COPY;
                            end else begin
                                n_row   = r_row + 7'd1;
                                n_lc    = 7'd0;
                                n_mid   = 3'd0;
                                n_right = 3'd0;
                            end
                        end else begin
                            n_lc = r_lc + 7'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_COPY: begin
                // read scratch, write it back in the following cycle
                n_wb_valid = r_cp_go;
                n_wb_addr  = next_raddr;
                if (r_cp_go) begin
                    if (r_cc == side - 7'd1) begin
                        n_cc = 7'd0;
                        if (r_cr == side - 7'd1) begin
                            n_cp_go = 1'b0;
                        end else begin
                            n_cr = r_cr + 7'd1;
                        end
                    end else begin
                        n_cc = r_cc + 7'd1;
                    end
                end else begin
                    res_go = 1'b1;
                end
            end
            ST_FIN: begin
                res_go    = 1'b1;
                res_value = r_res_value;
                res_err   = r_res_err;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand the result to the output register or park it
        if (res_go) begin
            if (out_free) begin
                n_out_valid   = 1'b1;
                n_read_value  = res_value;
                n_range_error = res_err;
                n_state       = ST_IDLE;
            end else begin
                n_res_value = res_value;
                n_res_err   = res_err;
                n_state     = ST_FIN;
            end
        end
    end

    // sequencer state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr         <= 12'd0;
            r_row         <= 7'd0;
            r_lc          <= 7'd0;
            r_k           <= 2'd0;
            r_pend_ok     <= 1'b0;
            r_cp_go       <= 1'b0;
            r_wb_valid    <= 1'b0;
            r_cr          <= 7'd0;
            r_cc          <= 7'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_row         <= n_row;
            r_lc          <= n_lc;
            r_k           <= n_k;
            r_pend_ok     <= n_pend_ok;
            r_cp_go       <= n_cp_go;
            r_wb_valid    <= n_wb_valid;
            r_cr          <= n_cr;
            r_cc          <= n_cc;
            r_out_valid   <= n_out_valid;
        end
        r_cap         <= n_cap;
        r_cap_stat    <= n_cap_stat;
        r_mid         <= n_mid;
        r_right       <= n_right;
        r_right_stat  <= n_right_stat;
        r_wb_addr     <= n_wb_addr;
        r_read_value  <= n_read_value;
        r_range_error <= n_range_error;
        r_res_value   <= n_res_value;
        r_res_err     <= n_res_err;
    end

    // board size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= alas_pkg::BOARD_SIZE_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == alas_pkg::REG_BOARD_SIZE)) begin
            r_board_size <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == alas_pkg::REG_BOARD_SIZE) ? {25'd0, r_board_size} : 32'd0;
    assign pready = 1'b1;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_range_error = r_range_error;

endmodule

/* rtl/alas_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module alas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_read_value,
    input logic        o_range_error,
    input logic [2:0]  paddr,
    input logic [31:0] prdata,
    input logic        pready
);

    // a stalled result transfer stays offered
    `ALAS_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall |=> o_out_valid), "result dropped while stalled")

    // a flagged access never carries cell data
    `ALAS_ASSERT(a_err_no_data, i_clk, i_rst_n, (o_out_valid && o_range_error |-> o_read_value == 3'd0), "range error with nonzero read value")

    // a read value is always a legal cell status
    `ALAS_ASSERT(a_status_legal, i_clk, i_rst_n, (o_out_valid |-> o_read_value <= alas_pkg::DEAD_STATUS), "read value beyond dead status")

    // an accepted transfer either keeps the block busy or offers its result
    `ALAS_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall |=> o_in_stall || o_out_valid), "accepted item lost")

    // board size readback fits its register and the port never waits
    `ALAS_ASSERT_ALWAYS(a_cfg_read, i_clk, (pready && ((paddr[2] != alas_pkg::REG_BOARD_SIZE) || (prdata[31:7] == 25'd0))), "register port readback out of range")

endmodule

bind aging_life_automaton_step_core alas_checker u_alas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_read_value  (o_read_value),
    .o_range_error (o_range_error),
    .paddr         (paddr),
    .prdata        (prdata),
    .pready        (pready)
);
